[rtl/tpc_pkg.sv]
package tpc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LAST = 8'd3;

	// Field widths.
	localparam int RAW_W = 20;
	localparam int OUT_W = 32;

	// Divider geometry: 64-bit dividend, divisor magnitude of at most 2^30.
	localparam int DIV_W = 64;
	localparam int DEN_W = 31;
	localparam int REM_W = DEN_W + 1;

	// Compensation constants.
	localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
	localparam logic [20:0] PRESS_BASE = 21'd1048576;
	localparam logic [11:0] PRESS_SCALE = 12'd3125;
	localparam logic [63:0] V1_BIAS = 64'h0000_8000_0000_0000;

	// Unpacked calibration words.
	typedef struct packed {
		logic [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} tpc_calib_t;

endpackage

[rtl/tpc_cfg.sv]
module tpc_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data,
	output tpc_pkg::tpc_calib_t calib
);

	logic [47:0] temp_calib_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_last_q;

	assign cfg_ready = 1'b1;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q <= '0;
			press_high_q <= '0;
			press_last_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tpc_pkg::REG_TEMP_CALIB: temp_calib_q <= cfg_data[47:0];
				tpc_pkg::REG_PRESS_LOW: press_low_q <= cfg_data;
				tpc_pkg::REG_PRESS_HIGH: press_high_q <= cfg_data;
				tpc_pkg::REG_PRESS_LAST: press_last_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Split the packed words into calibration fields.
	always_comb begin
		calib.t1 = temp_calib_q[15:0];
		calib.t2 = temp_calib_q[31:16];
		calib.t3 = temp_calib_q[47:32];
		calib.p1 = press_low_q[15:0];
		calib.p2 = press_low_q[31:16];
		calib.p3 = press_low_q[47:32];
		calib.p4 = press_low_q[63:48];
		calib.p5 = press_high_q[15:0];
		calib.p6 = press_high_q[31:16];
		calib.p7 = press_high_q[47:32];
		calib.p8 = press_high_q[63:48];
		calib.p9 = press_last_q;
	end

endmodule

[rtl/tpc_temp.sv]
module tpc_temp (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [tpc_pkg::RAW_W-1:0] raw_pressure,
	input  logic [tpc_pkg::RAW_W-1:0] raw_temperature,
	input  tpc_pkg::tpc_calib_t calib,
	output logic out_valid,
	output logic signed [31:0] fine,
	output logic signed [31:0] tcent,
	output logic [tpc_pkg::RAW_W-1:0] raw_p
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [17:0] x1_s1;
	logic signed [16:0] d_s1;
	logic signed [31:0] ap_s2, dd_s2;
	logic signed [31:0] a_s3, bp_s3;
	logic signed [31:0] fine_s4;
	logic signed [31:0] fine_s5, tcent_s5;
	logic [tpc_pkg::RAW_W-1:0] rawp_s1, rawp_s2, rawp_s3, rawp_s4, rawp_s5;

	logic signed [17:0] x1_c;
	logic signed [16:0] d_c;
	logic signed [33:0] ap_c, dd_c;
	logic signed [31:0] dsh_c;
	logic signed [47:0] bp_c;
	logic signed [31:0] bsh_c, fine_c, t5_c, tc_c;

	// Temperature formula in 32-bit wrapping arithmetic.
	always_comb begin
		x1_c = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
		d_c = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, calib.t1});
		ap_c = x1_s1 * calib.t2;
		dd_c = d_s1 * d_s1;
		dsh_c = dd_s2 >>> 12;
		bp_c = dsh_c * calib.t3;
		bsh_c = bp_s3 >>> 14;
		fine_c = a_s3 + bsh_c;
		t5_c = (fine_s4 <<< 2) + fine_s4 + 32'sd128;
		tc_c = t5_c >>> 8;
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= x1_c;
			d_s1 <= d_c;
			rawp_s1 <= raw_pressure;
			ap_s2 <= ap_c[31:0];
			dd_s2 <= dd_c[31:0];
			rawp_s2 <= rawp_s1;
			a_s3 <= ap_s2 >>> 11;
			bp_s3 <= bp_c[31:0];
			rawp_s3 <= rawp_s2;
			fine_s4 <= fine_c;
			rawp_s4 <= rawp_s3;
			fine_s5 <= fine_s4;
			tcent_s5 <= tc_c;
			rawp_s5 <= rawp_s4;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_valid = vld_s5;
	assign fine = fine_s5;
	assign tcent = tcent_s5;
	assign raw_p = rawp_s5;

endmodule

[rtl/tpc_coef.sv]
module tpc_coef (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic signed [31:0] fine,
	input  logic signed [31:0] tcent_in,
	input  logic [tpc_pkg::RAW_W-1:0] raw_p,
	input  tpc_pkg::tpc_calib_t calib,
	output logic out_valid,
	output logic [63:0] num,
	output logic signed [tpc_pkg::DEN_W-1:0] den,
	output logic signed [31:0] tcent_out
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [31:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6, tc_s7, tc_s8;
	logic [20:0] pd_s1, pd_s2, pd_s3, pd_s4, pd_s5;
	logic signed [32:0] v1_s1;
	logic [31:0] mag_s1;
	logic [63:0] sq_s2;
	logic signed [48:0] m5_s2, m5_s3, m5_s4;
	logic signed [48:0] m2_s2, m2_s3, m2_s4;
	logic signed [48:0] q6lo_s3, q3lo_s3;
	logic [31:0] q6hi_s3, q3hi_s3;
	logic [63:0] t6_s4, t3_s4;
	logic [63:0] v2_s5, v1b_s5;
	logic [63:0] x_s6, n0_s6;
	logic [47:0] xlo_s7;
	logic [31:0] xhi_s7;
	logic [43:0] nlo_s7;
	logic [31:0] nhi_s7;
	logic [63:0] num_s8;
	logic signed [tpc_pkg::DEN_W-1:0] den_s8;

	logic signed [32:0] v1_c, nv1_c;
	logic signed [48:0] q6lo_c, q6hi_c, q3lo_c, q3hi_c;
	logic [63:0] t3x_c, m5x_c, m2x_c, p4x_c, v2_c, v1b_c;
	logic signed [63:0] t3sh_c;
	logic [47:0] xhi_c;
	logic [43:0] nhi_c;
	logic [63:0] xp_c, num_c;

	// Pressure coefficients in 64-bit wrapping arithmetic; wide products are
	// split into 32-bit halves.
	always_comb begin
		v1_c = $signed({fine[31], fine}) - tpc_pkg::FINE_OFFSET;
		nv1_c = -v1_c;
		q6lo_c = $signed({1'b0, sq_s2[31:0]}) * calib.p6;
		q6hi_c = $signed({1'b0, sq_s2[63:32]}) * calib.p6;
		q3lo_c = $signed({1'b0, sq_s2[31:0]}) * calib.p3;
		q3hi_c = $signed({1'b0, sq_s2[63:32]}) * calib.p3;
		t3x_c = t3_s4;
		t3sh_c = $signed(t3x_c) >>> 8;
		m5x_c = {{15{m5_s4[48]}}, m5_s4};
		m2x_c = {{15{m2_s4[48]}}, m2_s4};
		p4x_c = {{48{calib.p4[15]}}, calib.p4};
		v2_c = t6_s4 + (m5x_c << 17) + (p4x_c << 35);
		v1b_c = t3sh_c + (m2x_c << 12);
		xhi_c = x_s6[63:32] * calib.p1;
		nhi_c = n0_s6[63:32] * tpc_pkg::PRESS_SCALE;
		xp_c = {16'd0, xlo_s7} + {xhi_s7, 32'd0};
		num_c = {20'd0, nlo_s7} + {nhi_s7, 32'd0};
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s1 <= v1_c;
			mag_s1 <= v1_c[32] ? nv1_c[31:0] : v1_c[31:0];
			pd_s1 <= tpc_pkg::PRESS_BASE - {1'b0, raw_p};
			tc_s1 <= tcent_in;

			sq_s2 <= mag_s1 * mag_s1;
			m5_s2 <= v1_s1 * calib.p5;
			m2_s2 <= v1_s1 * calib.p2;
			pd_s2 <= pd_s1;
			tc_s2 <= tc_s1;

			q6lo_s3 <= q6lo_c;
			q6hi_s3 <= q6hi_c[31:0];
			q3lo_s3 <= q3lo_c;
			q3hi_s3 <= q3hi_c[31:0];
			m5_s3 <= m5_s2;
			m2_s3 <= m2_s2;
			pd_s3 <= pd_s2;
			tc_s3 <= tc_s2;

			t6_s4 <= {{15{q6lo_s3[48]}}, q6lo_s3} + {q6hi_s3, 32'd0};
			t3_s4 <= {{15{q3lo_s3[48]}}, q3lo_s3} + {q3hi_s3, 32'd0};
			m5_s4 <= m5_s3;
			m2_s4 <= m2_s3;
			pd_s4 <= pd_s3;
			tc_s4 <= tc_s3;

			v2_s5 <= v2_c;
			v1b_s5 <= v1b_c;
			pd_s5 <= pd_s4;
			tc_s5 <= tc_s4;

			x_s6 <= v1b_s5 + tpc_pkg::V1_BIAS;
			n0_s6 <= {12'd0, pd_s5, 31'd0} - v2_s5;
			tc_s6 <= tc_s5;

			xlo_s7 <= x_s6[31:0] * calib.p1;
			xhi_s7 <= xhi_c[31:0];
			nlo_s7 <= n0_s6[31:0] * tpc_pkg::PRESS_SCALE;
			nhi_s7 <= nhi_c[31:0];
			tc_s7 <= tc_s6;

			num_s8 <= num_c;
			den_s8 <= xp_c[63:33];
			tc_s8 <= tc_s7;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign out_valid = vld_s8;
	assign num = num_s8;
	assign den = den_s8;
	assign tcent_out = tc_s8;

endmodule

[rtl/tpc_div.sv]
module tpc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [tpc_pkg::DIV_W-1:0] num,
	input  logic signed [tpc_pkg::DEN_W-1:0] den,
	input  logic signed [31:0] tcent_in,
	output logic out_valid,
	output logic [tpc_pkg::DIV_W-1:0] quo,
	output logic den_zero,
	output logic signed [31:0] tcent_out
);

	localparam int DIV_W = tpc_pkg::DIV_W;
	localparam int DEN_W = tpc_pkg::DEN_W;
	localparam int REM_W = tpc_pkg::REM_W;

	// Stage 0 holds the magnitudes; stage k has produced k quotient bits.
	logic [DIV_W-1:0] wrk_s [0:DIV_W];
	logic [REM_W-1:0] rem_s [0:DIV_W-1];
	logic [DEN_W-1:0] mb_s [0:DIV_W-1];
	logic neg_s [0:DIV_W];
	logic zero_s [0:DIV_W];
	logic signed [31:0] tc_s [0:DIV_W];
	logic vld_s [0:DIV_W];

	logic [DIV_W-1:0] quo_sl;
	logic zero_sl;
	logic signed [31:0] tc_sl;
	logic vld_sl;

	logic [DIV_W-1:0] neg_num_c, neg_wrk_c;
	logic [DEN_W-1:0] neg_den_c;

	always_comb begin
		neg_num_c = '0 - num;
		neg_den_c = '0 - den;
		neg_wrk_c = '0 - wrk_s[DIV_W];
	end

	// Signs and magnitudes of both operands.
	always_ff @(posedge clk) begin
		if (adv) begin
			wrk_s[0] <= num[DIV_W-1] ? neg_num_c : num;
			mb_s[0] <= den[DEN_W-1] ? neg_den_c : den;
			rem_s[0] <= '0;
			neg_s[0] <= num[DIV_W-1] ^ den[DEN_W-1];
			zero_s[0] <= (den == '0);
			tc_s[0] <= tcent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	// One restoring step per stage.
	for (genvar k = 1; k <= DIV_W; k++) begin : g_step
		logic [REM_W-1:0] trial;
		logic [REM_W-1:0] diff;
		logic ge;

		always_comb begin
			trial = {rem_s[k-1][REM_W-2:0], wrk_s[k-1][DIV_W-1]};
			diff = trial - {1'b0, mb_s[k-1]};
			ge = (trial >= {1'b0, mb_s[k-1]});
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				wrk_s[k] <= {wrk_s[k-1][DIV_W-2:0], ge};
				neg_s[k] <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				tc_s[k] <= tc_s[k-1];
			end
		end

		if (k < DIV_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k] <= ge ? diff : trial;
					mb_s[k] <= mb_s[k-1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Apply the quotient sign.
	always_ff @(posedge clk) begin
		if (adv) begin
			quo_sl <= neg_s[DIV_W] ? neg_wrk_c : wrk_s[DIV_W];
			zero_sl <= zero_s[DIV_W];
			tc_sl <= tc_s[DIV_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sl <= 1'b0;
		end else if (adv) begin
			vld_sl <= vld_s[DIV_W];
		end
	end

	assign out_valid = vld_sl;
	assign quo = quo_sl;
	assign den_zero = zero_sl;
	assign tcent_out = tc_sl;

endmodule

[rtl/tpc_post.sv]
module tpc_post (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [63:0] quo,
	input  logic den_zero,
	input  logic signed [31:0] tcent_in,
	input  tpc_pkg::tpc_calib_t calib,
	output logic out_valid,
	output logic signed [31:0] tcent_out,
	output logic [tpc_pkg::OUT_W-1:0] pressure,
	output logic pressure_ok
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [31:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6, tc_s7;
	logic zr_s1, zr_s2, zr_s3, zr_s4, zr_s5, zr_s6;
	logic signed [63:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [63:0] ps_s1;
	logic signed [48:0] m8lo_s1;
	logic [31:0] m8hi_s1;
	logic [63:0] sql_s2;
	logic [31:0] cr_s2;
	logic [63:0] w2f_s2;
	logic [63:0] sq_s3;
	logic signed [63:0] w2_s3, w2_s4, w2_s5;
	logic signed [48:0] q9lo_s4;
	logic [31:0] q9hi_s4;
	logic [63:0] w1f_s5;
	logic signed [63:0] s_s6;
	logic [tpc_pkg::OUT_W-1:0] press_s7;
	logic ok_s7;

	logic signed [63:0] ps_c, w2sh_c, w1_c, ssh_c, p7x_c, r_c;
	logic signed [48:0] m8lo_c, m8hi_c, q9lo_c, q9hi_c;
	logic [63:0] cr_c;
	logic [tpc_pkg::OUT_W-1:0] sat_c;

	// Second-order correction terms and the final saturation.
	always_comb begin
		ps_c = $signed(quo) >>> 13;
		m8lo_c = $signed({1'b0, quo[31:0]}) * calib.p8;
		m8hi_c = $signed({1'b0, quo[63:32]}) * calib.p8;
		cr_c = ps_s1[63:32] * ps_s1[31:0];
		w2sh_c = $signed(w2f_s2) >>> 19;
		q9lo_c = $signed({1'b0, sq_s3[31:0]}) * calib.p9;
		q9hi_c = $signed({1'b0, sq_s3[63:32]}) * calib.p9;
		w1_c = $signed(w1f_s5) >>> 25;
		ssh_c = s_s6 >>> 8;
		p7x_c = 64'(calib.p7) <<< 4;
		r_c = ssh_c + p7x_c;
		if (r_c[63]) begin
			sat_c = '0;
		end else if (r_c[63:32] != 32'd0) begin
			sat_c = '1;
		end else begin
			sat_c = r_c[31:0];
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			ps_s1 <= ps_c;
			m8lo_s1 <= m8lo_c;
			m8hi_s1 <= m8hi_c[31:0];
			p_s1 <= quo;
			zr_s1 <= den_zero;
			tc_s1 <= tcent_in;

			sql_s2 <= ps_s1[31:0] * ps_s1[31:0];
			cr_s2 <= cr_c[31:0];
			w2f_s2 <= {{15{m8lo_s1[48]}}, m8lo_s1} + {m8hi_s1, 32'd0};
			p_s2 <= p_s1;
			zr_s2 <= zr_s1;
			tc_s2 <= tc_s1;

			sq_s3 <= sql_s2 + {cr_s2[30:0], 33'd0};
			w2_s3 <= w2sh_c;
			p_s3 <= p_s2;
			zr_s3 <= zr_s2;
			tc_s3 <= tc_s2;

			q9lo_s4 <= q9lo_c;
			q9hi_s4 <= q9hi_c[31:0];
			w2_s4 <= w2_s3;
			p_s4 <= p_s3;
			zr_s4 <= zr_s3;
			tc_s4 <= tc_s3;

			w1f_s5 <= {{15{q9lo_s4[48]}}, q9lo_s4} + {q9hi_s4, 32'd0};
			w2_s5 <= w2_s4;
			p_s5 <= p_s4;
			zr_s5 <= zr_s4;
			tc_s5 <= tc_s4;

			s_s6 <= p_s5 + w1_c + w2_s5;
			zr_s6 <= zr_s5;
			tc_s6 <= tc_s5;

			press_s7 <= zr_s6 ? '0 : sat_c;
			ok_s7 <= ~zr_s6;
			tc_s7 <= tc_s6;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign out_valid = vld_s7;
	assign tcent_out = tc_s7;
	assign pressure = press_s7;
	assign pressure_ok = ok_s7;

endmodule

[rtl/temp_pressure_compensation.sv]
// Throughput: one reading per cycle while no result waits on m_tready.
// The radix-2 divider, with a stage for each of its 64 restoring steps, sets most of the depth.
// The whole pipeline holds while a result waits on m_tready, so nothing is lost or repeated.
// Reset (arst_n, asynchronous, active low) clears all valid bits and the calibration
// registers to zero; configuration writes are accepted in every cycle.
module temp_pressure_compensation (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata,  // raw_pressure [19:0], raw_temperature [39:20]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [63:0] m_tdata,  // temperature_centi [31:0], pressure_q24_8 [63:32]
	output logic m_tuser,         // pressure_valid [0]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	tpc_pkg::tpc_calib_t calib;
	logic adv;

	logic t_valid;
	logic signed [31:0] t_fine, t_tcent;
	logic [tpc_pkg::RAW_W-1:0] t_rawp;

	logic c_valid;
	logic [63:0] c_num;
	logic signed [tpc_pkg::DEN_W-1:0] c_den;
	logic signed [31:0] c_tcent;

	logic d_valid, d_zero;
	logic [63:0] d_quo;
	logic signed [31:0] d_tcent;

	logic signed [31:0] o_tcent;
	logic [tpc_pkg::OUT_W-1:0] o_press;
	logic o_ok;

	// The pipeline moves whenever the output register is free or being drained.
	assign adv = ~m_tvalid | m_tready;
	assign s_tready = adv;

	tpc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.calib(calib)
	);

	tpc_temp u_temp (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(s_tvalid),
		.raw_pressure(s_tdata[19:0]),
		.raw_temperature(s_tdata[39:20]),
		.calib(calib),
		.out_valid(t_valid),
		.fine(t_fine),
		.tcent(t_tcent),
		.raw_p(t_rawp)
	);

	tpc_coef u_coef (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(t_valid),
		.fine(t_fine),
		.tcent_in(t_tcent),
		.raw_p(t_rawp),
		.calib(calib),
		.out_valid(c_valid),
		.num(c_num),
		.den(c_den),
		.tcent_out(c_tcent)
	);

	tpc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(c_valid),
		.num(c_num),
		.den(c_den),
		.tcent_in(c_tcent),
		.out_valid(d_valid),
		.quo(d_quo),
		.den_zero(d_zero),
		.tcent_out(d_tcent)
	);

	tpc_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(d_valid),
		.quo(d_quo),
		.den_zero(d_zero),
		.tcent_in(d_tcent),
		.calib(calib),
		.out_valid(m_tvalid),
		.tcent_out(o_tcent),
		.pressure(o_press),
		.pressure_ok(o_ok)
	);

	assign m_tdata = {o_press, o_tcent};
	assign m_tuser = o_ok;

endmodule
